// File: rtl/bounded_list_deque_with_erase_unit_assert.svh
// Assertion macros used by the checker of the deque unit.
`ifndef BOUNDED_LIST_DEQUE_WITH_ERASE_UNIT_ASSERT_SVH
`define BOUNDED_LIST_DEQUE_WITH_ERASE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BLDE_ASSERT_SAME(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("deque unit assertion failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define BLDE_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("deque unit assertion failed in the next cycle");

`endif

// File: rtl/blde_pkg.sv
// Types and codes shared by the deque unit, its cells and its checker.
package blde_pkg;

    localparam logic [2:0] CMD_PUSH_BACK  = 3'd0;
    localparam logic [2:0] CMD_PUSH_FRONT = 3'd1;
    localparam logic [2:0] CMD_POP_BACK   = 3'd2;
    localparam logic [2:0] CMD_POP_FRONT  = 3'd3;
    localparam logic [2:0] CMD_ERASE      = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [31:0] value;
    } request_t;

    typedef struct packed {
        logic [1:0] status;
        logic [4:0] count;
        logic       is_empty;
    } result_t;

    typedef enum logic [2:0] {
        MODE_HOLD,
        MODE_APPEND,
        MODE_SHIFT_IN,
        MODE_SHIFT_OUT,
        MODE_ERASE
    } cell_mode_t;

    typedef struct packed {
        cell_mode_t mode;
        logic       at_tail;
        logic       in_use;
    } cell_ctl_t;

endpackage

// File: rtl/blde_cell.sv
// One storage cell of the deque: holds one entry and shifts toward either neighbor.
module blde_cell (
    input  logic                clk,
    input  blde_pkg::cell_ctl_t ctl,
    input  logic signed [31:0]  value,
    input  logic signed [31:0]  left_data,
    input  logic signed [31:0]  right_data,
    input  logic                seen_in,
    output logic signed [31:0]  data,
    output logic                seen_out
);
    import blde_pkg::*;

    logic signed [31:0] data_reg;
    logic signed [31:0] data_next;
    logic               hit;

    always_comb
    begin
        hit       = ctl.in_use && (data_reg == value);
        seen_out  = seen_in || hit;
        data_next = data_reg;
        case (ctl.mode)
            MODE_HOLD:
            begin
                data_next = data_reg;
            end
            MODE_APPEND:
            begin
                if (ctl.at_tail)
                begin
                    data_next = value;
                end
            end
            MODE_SHIFT_IN:
            begin
                data_next = left_data;
            end
            MODE_SHIFT_OUT:
            begin
                data_next = right_data;
            end
            MODE_ERASE:
            begin
                if (seen_out)
                begin
                    data_next = right_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// File: rtl/bounded_list_deque_with_erase_unit.sv
// Top level of the bounded deque with erase by value, built as a row of cells.
//
//  channel | direction | payload   | handshake
//  --------+-----------+-----------+--------------------------
//  in      | input     | request_t | in_valid / in_stall
//  out     | output    | result_t  | out_valid / out_stall
//
// Every request, erase included, completes as it is accepted, so one request is taken per clock while not stalled.
// The match search for an erase ripples combinationally through the row of cells.
// The result appears in the output register on the cycle after acceptance.
// Reset empties the deque at once; entry contents are left as they are.
// The input is stalled only while a finished result waits under a stall on the output.
module bounded_list_deque_with_erase_unit #(
    parameter int CAPACITY = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  blde_pkg::request_t in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output blde_pkg::result_t  out_data
);
    import blde_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic               out_valid_reg;
    result_t            out_data_reg;
    logic               accept;
    logic               full;
    logic               empty;
    logic               found;
    logic [1:0]         status;
    cell_mode_t         mode;
    cell_mode_t         cell_mode;
    logic signed [31:0] cell_data [CAPACITY];
    logic               seen [CAPACITY+1];

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign full     = (count_reg == CW'(CAPACITY));
    assign empty    = (count_reg == '0);
    assign seen[0]  = 1'b0;
    assign found    = seen[CAPACITY];

    always_comb
    begin
        mode       = MODE_HOLD;
        status     = ST_OK;
        count_next = count_reg;
        case (in_data.cmd)
            CMD_PUSH_BACK:
            begin
                if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    mode       = MODE_APPEND;
                    count_next = count_reg + CW'(1);
                end
            end
            CMD_PUSH_FRONT:
            begin
                if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    mode       = MODE_SHIFT_IN;
                    count_next = count_reg + CW'(1);
                end
            end
            CMD_POP_BACK:
            begin
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                end
            end
            CMD_POP_FRONT:
            begin
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    mode       = MODE_SHIFT_OUT;
                    count_next = count_reg - CW'(1);
                end
            end
            CMD_ERASE:
            begin
                if (!found)
                begin
                    status = ST_NOT_FOUND;
                end
                else
                begin
                    mode       = MODE_ERASE;
                    count_next = count_reg - CW'(1);
                end
            end
            default:
            begin
                mode = MODE_HOLD;
            end
        endcase
    end

    assign cell_mode = accept ? mode : MODE_HOLD;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        cell_ctl_t          ctl;
        logic signed [31:0] left_data;
        logic signed [31:0] right_data;

        assign ctl.mode    = cell_mode;
        assign ctl.at_tail = (count_reg == CW'(i));
        assign ctl.in_use  = (CW'(i) < count_reg);

        if (i == 0)
        begin : g_first
            assign left_data = in_data.value;
        end
        else
        begin : g_inner_left
            assign left_data = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_data = cell_data[i];
        end
        else
        begin : g_inner_right
            assign right_data = cell_data[i+1];
        end

        blde_cell u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .value      (in_data.value),
            .left_data  (left_data),
            .right_data (right_data),
            .seen_in    (seen[i]),
            .data       (cell_data[i]),
            .seen_out   (seen[i+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg.status   <= status;
            out_data_reg.count    <= 5'(count_next);
            out_data_reg.is_empty <= (count_next == '0);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: rtl/blde_checker.sv
// Port-level checker for the deque unit and the bind that attaches it.
`include "bounded_list_deque_with_erase_unit_assert.svh"

module blde_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input blde_pkg::result_t out_data
);
    import blde_pkg::*;

    `BLDE_ASSERT_NEXT(a_out_held, out_valid && out_stall, out_valid)
    `BLDE_ASSERT_NEXT(a_request_answered, in_valid && !in_stall, out_valid)
    `BLDE_ASSERT_SAME(a_stall_cause, in_stall, out_valid && out_stall)
    `BLDE_ASSERT_SAME(a_empty_pop, out_valid && (out_data.status == ST_EMPTY), out_data.is_empty)
    `BLDE_ASSERT_SAME(a_full_push, out_valid && (out_data.status == ST_FULL), !out_data.is_empty)

endmodule

bind bounded_list_deque_with_erase_unit blde_checker u_blde_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
